/* rtl/rct_pkg.sv */
// Shared types, constants and status codes of the rigid coordinate transform.
`default_nettype none
package rct_pkg;

    localparam int DIM        = 3;
    localparam int COORD_W    = 32;
    localparam int MAT_W      = 21;
    localparam int MAT_FRAC   = 18;
    localparam int ROW_W      = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int ADJ_W      = 25;   // rounded cofactor, Q18
    localparam int DETQ_W     = 28;   // magnitude of rounded determinant, Q18
    localparam int DIV_STEPS  = 2;    // quotient bits per divider stage
    localparam int DIV_STAGES = COORD_W / DIV_STEPS;

    localparam logic [ROW_W-1:0] ROW0_RST = ROW_W'(1) << MAT_FRAC;
    localparam logic [ROW_W-1:0] ROW1_RST = ROW_W'(1) << (MAT_FRAC + MAT_W);
    localparam logic [ROW_W-1:0] ROW2_RST = ROW_W'(1) << (MAT_FRAC + 2 * MAT_W);

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0  = 3'd0,
        CFG_ROW1  = 3'd1,
        CFG_ROW2  = 3'd2,
        CFG_TX    = 3'd3,
        CFG_TY    = 3'd4,
        CFG_TZ    = 3'd5,
        CFG_DIR   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
    } point_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_x;
        logic signed [COORD_W-1:0] result_y;
        logic signed [COORD_W-1:0] result_z;
        logic        [1:0]         status;
    } result_t;

    // Determinant summary handed to the lanes
    typedef struct packed {
        logic [DETQ_W-1:0] mag;
        logic              neg;
        logic              zero;
    } det_t;

endpackage
`default_nettype wire

/* rtl/rct_cof.sv */
// Cofactor and determinant unit: rounded adjugate and determinant of R.
`default_nettype none
module rct_cof (
    input  wire logic                              aclk,
    input  wire logic signed [rct_pkg::MAT_W-1:0]  ent [rct_pkg::DIM][rct_pkg::DIM],
    output logic signed [rct_pkg::ADJ_W-1:0]       adjq [rct_pkg::DIM][rct_pkg::DIM],
    output rct_pkg::det_t                          det_info
);
    localparam int PW = 2 * rct_pkg::MAT_W;   // 2x2 minor product
    localparam int CW = PW + 1;               // cofactor
    localparam int DW = 64;                   // determinant, Q54

    localparam logic signed [CW-1:0] RND_C = CW'(1) <<< (rct_pkg::MAT_FRAC - 1);
    localparam logic signed [DW-1:0] RND_D = DW'(1) <<< (2 * rct_pkg::MAT_FRAC - 1);

    logic signed [PW-1:0] pa_reg  [rct_pkg::DIM][rct_pkg::DIM];
    logic signed [PW-1:0] pb_reg  [rct_pkg::DIM][rct_pkg::DIM];
    logic signed [CW-1:0] cof_reg [rct_pkg::DIM][rct_pkg::DIM];
    logic signed [DW-1:0] dp_reg  [rct_pkg::DIM];
    logic signed [rct_pkg::ADJ_W-1:0] adjq_reg [rct_pkg::DIM][rct_pkg::DIM];
    rct_pkg::det_t det_reg;

    logic signed [CW-1:0] cof_r [rct_pkg::DIM][rct_pkg::DIM];
    logic signed [DW-1:0] det_sum;
    logic signed [rct_pkg::DETQ_W-1:0] detq;

    // Cofactor rounding and determinant sum
    always_comb begin
        for (int i = 0; i < rct_pkg::DIM; i++) begin
            for (int j = 0; j < rct_pkg::DIM; j++) begin
                cof_r[i][j] = cof_reg[i][j] + RND_C;
            end
        end
        det_sum = dp_reg[0] + dp_reg[1] + dp_reg[2] + RND_D;
        detq    = signed'(det_sum[DW-1:2*rct_pkg::MAT_FRAC]);
    end

    // Free-running chain; the user must change R only while no transaction is in flight, as the block does not check it
    always_ff @(posedge aclk) begin
        for (int i = 0; i < rct_pkg::DIM; i++) begin
            for (int j = 0; j < rct_pkg::DIM; j++) begin
                pa_reg[i][j]  <= ent[(i+1)%3][(j+1)%3] * ent[(i+2)%3][(j+2)%3];
                pb_reg[i][j]  <= ent[(i+1)%3][(j+2)%3] * ent[(i+2)%3][(j+1)%3];
                cof_reg[i][j] <= CW'(pa_reg[i][j]) - CW'(pb_reg[i][j]);
                // adjugate is the transposed cofactor matrix
                adjq_reg[i][j] <= signed'(cof_r[j][i][CW-1:rct_pkg::MAT_FRAC]);
            end
            dp_reg[i] <= DW'(ent[0][i]) * DW'(cof_reg[0][i]);
        end
        det_reg.neg  <= detq[rct_pkg::DETQ_W-1];
        det_reg.zero <= (detq == '0);
        det_reg.mag  <= detq[rct_pkg::DETQ_W-1] ? rct_pkg::DETQ_W'(-detq)
                                                  : rct_pkg::DETQ_W'(detq);
    end

    assign adjq     = adjq_reg;
    assign det_info = det_reg;

endmodule
`default_nettype wire

/* rtl/rct_lane.sv */
// One coordinate lane: forward dot product, inverse dot product and divider.
`default_nettype none
module rct_lane (
    input  wire logic                                  aclk,
    input  wire logic                                  en,
    input  wire logic                                  dir,
    input  wire logic signed [rct_pkg::MAT_W-1:0]      m_row  [rct_pkg::DIM],
    input  wire logic signed [rct_pkg::COORD_W-1:0]    p_vec  [rct_pkg::DIM],
    input  wire logic signed [rct_pkg::COORD_W-1:0]    t_i,
    input  wire logic signed [rct_pkg::COORD_W:0]      d_vec  [rct_pkg::DIM],
    input  wire logic signed [rct_pkg::ADJ_W-1:0]      adj_row [rct_pkg::DIM],
    input  wire rct_pkg::det_t                         det_info,
    output logic signed [rct_pkg::COORD_W-1:0]         res,
    output logic                                       sat
);
    localparam int CW   = rct_pkg::COORD_W;
    localparam int FPW  = rct_pkg::MAT_W + CW;        // forward product
    localparam int FSW  = FPW + 2;                     // forward sum
    localparam int FRW  = FSW - rct_pkg::MAT_FRAC;     // rounded sum
    localparam int FVW  = FRW + 1;                     // plus translation
    localparam int NPW  = rct_pkg::ADJ_W + CW + 1;     // inverse product
    localparam int NSW  = NPW + 2;                     // inverse sum
    localparam int NUMW = NSW + 1;                     // rounded dividend
    localparam int RW   = rct_pkg::DETQ_W;
    localparam int NST  = rct_pkg::DIV_STAGES;
    localparam int FWD_LEN = 4 + NST;

    localparam logic signed [FSW-1:0] RND_F = FSW'(1) <<< (rct_pkg::MAT_FRAC - 1);

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [CW-1:0] nlo;
        logic [CW-1:0] q;
    } dv_t;

    typedef struct packed {
        logic                 fsat;
        logic signed [CW-1:0] fval;
    } fwd_t;

    // Restoring division, DIV_STEPS quotient bits
    function automatic dv_t div_step(dv_t a, logic [RW-1:0] dm);
        dv_t         r;
        logic [RW:0] t;
        r = a;
        for (int s = 0; s < rct_pkg::DIV_STEPS; s++) begin
            t     = {r.rem, r.nlo[CW-1]};
            r.nlo = {r.nlo[CW-2:0], 1'b0};
            if (t >= {1'b0, dm}) begin
                t   = t - {1'b0, dm};
                r.q = {r.q[CW-2:0], 1'b1};
            end else begin
                r.q = {r.q[CW-2:0], 1'b0};
            end
            r.rem = t[RW-1:0];
        end
        return r;
    endfunction

    logic signed [FPW-1:0] fp_reg [rct_pkg::DIM];
    logic signed [NPW-1:0] np_reg [rct_pkg::DIM];
    logic        [NSW-2:0] nmag_reg;
    logic                  nneg_reg;
    fwd_t                  fwd_reg [FWD_LEN];
    dv_t                   dv_reg  [NST+1];
    logic                  neg_reg [NST+1];
    logic                  ovf_reg [NST+1];

    logic signed [FSW-1:0] fsum;
    logic signed [FVW-1:0] fv;
    fwd_t                  fwd_next;
    logic signed [NSW-1:0] nsum;
    logic        [NUMW-1:0] num;
    dv_t                   dv_next;

    // Forward sum, rounding, translation and clamp
    always_comb begin
        fsum = FSW'(fp_reg[0]) + FSW'(fp_reg[1]) + FSW'(fp_reg[2]) + RND_F;
        fv   = FVW'(signed'(fsum[FSW-1:rct_pkg::MAT_FRAC])) + FVW'(t_i);
        fwd_next.fsat = 1'b0;
        fwd_next.fval = fv[CW-1:0];
        if (fv > FVW'(rct_pkg::COORD_MAX)) begin
            fwd_next.fsat = 1'b1;
            fwd_next.fval = rct_pkg::COORD_MAX;
        end else if (fv < FVW'(rct_pkg::COORD_MIN)) begin
            fwd_next.fsat = 1'b1;
            fwd_next.fval = rct_pkg::COORD_MIN;
        end
    end

    // Inverse sum and rounded dividend
    always_comb begin
        nsum = NSW'(np_reg[0]) + NSW'(np_reg[1]) + NSW'(np_reg[2]);
        num  = NUMW'(nmag_reg) + NUMW'(det_info.mag >> 1);
        dv_next.rem = num[CW+RW-1:CW];
        dv_next.nlo = num[CW-1:0];
        dv_next.q   = '0;
    end

    // Lane pipeline
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < rct_pkg::DIM; j++) begin
                fp_reg[j] <= m_row[j] * p_vec[j];
                np_reg[j] <= adj_row[j] * d_vec[j];
            end
            fwd_reg[0] <= fwd_next;
            for (int k = 1; k < FWD_LEN; k++) begin
                fwd_reg[k] <= fwd_reg[k-1];
            end
            nneg_reg <= nsum[NSW-1];
            nmag_reg <= nsum[NSW-1] ? (NSW-1)'(-nsum) : (NSW-1)'(nsum);
            dv_reg[0]  <= dv_next;
            neg_reg[0] <= nneg_reg ^ det_info.neg;
            // quotient of 2^COORD_W or more clamps either way
            ovf_reg[0] <= (num[NUMW-1:CW] >= (NUMW-CW)'(det_info.mag));
            for (int k = 1; k <= NST; k++) begin
                dv_reg[k]  <= div_step(dv_reg[k-1], det_info.mag);
                neg_reg[k] <= neg_reg[k-1];
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    // Result select, zero when singular, sign and clamp
    always_comb begin
        res = dv_reg[NST].q;
        sat = 1'b0;
        if (!dir) begin
            res = fwd_reg[FWD_LEN-1].fval;
            sat = fwd_reg[FWD_LEN-1].fsat;
        end else if (det_info.zero) begin
            res = '0;
        end else if (ovf_reg[NST]) begin
            sat = 1'b1;
            res = neg_reg[NST] ? rct_pkg::COORD_MIN : rct_pkg::COORD_MAX;
        end else if (neg_reg[NST]) begin
            if (dv_reg[NST].q[CW-1] && (|dv_reg[NST].q[CW-2:0])) begin
                sat = 1'b1;
                res = rct_pkg::COORD_MIN;
            end else begin
                res = -dv_reg[NST].q;
            end
        end else if (dv_reg[NST].q[CW-1]) begin
            sat = 1'b1;
            res = rct_pkg::COORD_MAX;
        end
    end

endmodule
`default_nettype wire

/* rtl/rigid_coordinate_transform.sv */
// Top level: registers, shared front end, three lanes, status merge and output skid.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------------------
//  input   | s_valid s_ready s_data         | point in, valid/ready
//  result  | m_valid m_ready m_data         | point out, valid/ready
//  config  | cfg_we cfg_index cfg_wdata     | write on cfg_we, no wait
//
//  One transaction per cycle while the skid buffer is not full; results pass
//  through the 16-stage divider (two quotient bits a stage) behind the lanes.
//  Reset clears the registers to identity R, zero T, forward mode.
//  A stalled result goes to a one-entry skid buffer; the pipeline holds
//  while the skid buffer is full, and s_ready follows it.
`default_nettype none
module rigid_coordinate_transform (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire rct_pkg::point_t                   s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output rct_pkg::result_t                       m_data,
    input  wire logic                              cfg_we,
    input  wire logic [rct_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [rct_pkg::ROW_W-1:0]         cfg_wdata
);
    localparam int DIM    = rct_pkg::DIM;
    localparam int CW     = rct_pkg::COORD_W;
    localparam int NSTAGE = 6 + rct_pkg::DIV_STAGES;

    // Configuration registers
    logic [rct_pkg::ROW_W-1:0] row_reg [DIM];
    logic signed [CW-1:0]      t_reg   [DIM];
    logic                      dir_reg;

    // Front end and control
    rct_pkg::point_t           p_reg;
    logic signed [CW:0]        d1_reg [DIM];
    logic signed [CW:0]        d2_reg [DIM];
    logic                      vld_reg [NSTAGE];
    rct_pkg::result_t          out_reg, skid_reg;
    logic                      out_v_reg, skid_v_reg;

    logic                      en;
    logic signed [rct_pkg::MAT_W-1:0]  ent [DIM][DIM];
    logic signed [CW-1:0]      p_arr [DIM];
    logic signed [rct_pkg::ADJ_W-1:0]  adjq [DIM][DIM];
    rct_pkg::det_t             det_info;
    logic signed [CW-1:0]      lane_res [DIM];
    logic                      lane_sat [DIM];
    rct_pkg::result_t          merged;

    assign en      = !skid_v_reg;
    assign s_ready = en;
    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    // Matrix entries and point as arrays
    always_comb begin
        for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
                ent[i][j] = signed'(row_reg[i][j*rct_pkg::MAT_W +: rct_pkg::MAT_W]);
            end
        end
        p_arr[0] = p_reg.point_x;
        p_arr[1] = p_reg.point_y;
        p_arr[2] = p_reg.point_z;
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg[0] <= rct_pkg::ROW0_RST;
            row_reg[1] <= rct_pkg::ROW1_RST;
            row_reg[2] <= rct_pkg::ROW2_RST;
            t_reg[0]   <= '0;
            t_reg[1]   <= '0;
            t_reg[2]   <= '0;
            dir_reg    <= 1'b0;
        end else if (cfg_we) begin
            unique case (rct_pkg::cfg_idx_t'(cfg_index))
                rct_pkg::CFG_ROW0: row_reg[0] <= cfg_wdata;
                rct_pkg::CFG_ROW1: row_reg[1] <= cfg_wdata;
                rct_pkg::CFG_ROW2: row_reg[2] <= cfg_wdata;
                rct_pkg::CFG_TX:   t_reg[0]   <= signed'(cfg_wdata[CW-1:0]);
                rct_pkg::CFG_TY:   t_reg[1]   <= signed'(cfg_wdata[CW-1:0]);
                rct_pkg::CFG_TZ:   t_reg[2]   <= signed'(cfg_wdata[CW-1:0]);
                rct_pkg::CFG_DIR:  dir_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input capture and shared difference B - T
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= s_data;
            for (int j = 0; j < DIM; j++) begin
                d1_reg[j] <= (CW+1)'(p_arr[j]) - (CW+1)'(t_reg[j]);
                d2_reg[j] <= d1_reg[j];
            end
        end
    end

    // Valid pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTAGE; k++) begin
                vld_reg[k] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < NSTAGE; k++) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    rct_cof u_cof (
        .aclk     (aclk),
        .ent      (ent),
        .adjq     (adjq),
        .det_info (det_info)
    );

    for (genvar i = 0; i < DIM; i++) begin : g_lane
        rct_lane u_lane (
            .aclk     (aclk),
            .en       (en),
            .dir      (dir_reg),
            .m_row    (ent[i]),
            .p_vec    (p_arr),
            .t_i      (t_reg[i]),
            .d_vec    (d2_reg),
            .adj_row  (adjq[i]),
            .det_info (det_info),
            .res      (lane_res[i]),
            .sat      (lane_sat[i])
        );
    end

    // Merge lane results into one status
    always_comb begin
        merged.result_x = lane_res[0];
        merged.result_y = lane_res[1];
        merged.result_z = lane_res[2];
        if (dir_reg && det_info.zero) begin
            merged.status = rct_pkg::ST_SINGULAR;
        end else if (lane_sat[0] || lane_sat[1] || lane_sat[2]) begin
            merged.status = rct_pkg::ST_SAT;
        end else begin
            merged.status = rct_pkg::ST_OK;
        end
    end

    // Output register with skid buffer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_ready || !out_v_reg) begin
            out_v_reg  <= skid_v_reg || vld_reg[NSTAGE-1];
            skid_v_reg <= 1'b0;
        end else if (en && vld_reg[NSTAGE-1]) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !out_v_reg) begin
            out_reg <= skid_v_reg ? skid_reg : merged;
        end else if (en && vld_reg[NSTAGE-1]) begin
            skid_reg <= merged;
        end
    end

    // Assertions
    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == rct_pkg::ST_SINGULAR |->
        m_data.result_x == '0 && m_data.result_y == '0 && m_data.result_z == '0)
        else $error("singular result is not zero");

    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |-> out_v_reg)
        else $error("skid buffer full while output register empty");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == rct_pkg::ST_OK ||
                     m_data.status == rct_pkg::ST_SINGULAR ||
                     m_data.status == rct_pkg::ST_SAT))
        else $error("undefined status code");

    a_fwd_not_singular: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !dir_reg |-> m_data.status != rct_pkg::ST_SINGULAR)
        else $error("singular status in forward mode");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> vld_reg[0])
        else $error("accepted transaction missing from pipeline");

endmodule
`default_nettype wire
